### src/cbq_pkg.sv
package cbq_pkg;

    localparam int SMP_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int FRAC_W  = 29;
    localparam int GFRAC_W = 12;
    localparam int NTAPS   = 5;
    localparam int CFG_W   = 3;
    localparam int LANES   = 2;

    localparam logic [CFG_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_W-1:0] REG_GAIN   = 3'd1;
    localparam logic [CFG_W-1:0] REG_FF0    = 3'd2;
    localparam logic [CFG_W-1:0] REG_FF1    = 3'd3;
    localparam logic [CFG_W-1:0] REG_FF2    = 3'd4;
    localparam logic [CFG_W-1:0] REG_FB1    = 3'd5;
    localparam logic [CFG_W-1:0] REG_FB2    = 3'd6;

    localparam logic [2:0] TAP_FF0  = 3'd0;
    localparam logic [2:0] TAP_FF1  = 3'd1;
    localparam logic [2:0] TAP_FF2  = 3'd2;
    localparam logic [2:0] TAP_FB1  = 3'd3;
    localparam logic [2:0] TAP_FB2  = 3'd4;
    localparam logic [2:0] TAP_LAST = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GAIN = 5'b00010,
        S_MAC  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] y2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] x1;
    } t_lane_hist;

    typedef t_lane_hist [LANES-1:0] t_hist;

    localparam int HIST_W = $bits(t_hist);

endpackage

### src/cbq_ram.sv
module cbq_ram #(
    parameter int WIDTH  = 256,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/complex_biquad_lowpass_cascade.sv
// Channel | Dir | Handshake              | Word
// s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata: i_sample, q_sample
// m       | out | o_m_tvalid/i_m_tready  | o_m_tdata: i_result, q_result
// cfg     | in  | i_cfg_we               | i_cfg_addr, i_cfg_wdata
// Filtering: one 32x32 multiplier per lane serves every tap, so each stage takes MAC steps
// over its five taps plus a product drain, then a write-back; stages run one after another.
// Pass-through: the word goes straight to the output state. A new word is taken only in idle.
// History lives in one RAM entry per stage (I and Q side by side); per-entry valid bits
// clear at reset and on any coefficient write, so no clearing pass is needed.
// A result waiting in the output register does not block the next input word.
module complex_biquad_lowpass_cascade
    import cbq_pkg::*;
#(
    parameter int STAGES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,   // [15:0] i_sample, [31:16] q_sample
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata,   // [15:0] i_result, [31:16] q_result
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_addr,
    input  logic [DATA_W-1:0]   i_cfg_wdata
);

    localparam int AW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic [AW-1:0] LAST_STAGE = AW'(STAGES - 1);

    t_state r_state;
    logic [2:0] r_tap;
    logic [AW-1:0] r_stage;
    logic [STAGES-1:0] r_valid;
    logic r_rd_valid;
    logic r_bypass;
    logic r_m_valid;
    logic [31:0] r_m_data;

    logic r_enable;
    logic [GAIN_W-1:0] r_gain;
    logic signed [DATA_W-1:0] r_coef [NTAPS];

    logic signed [SMP_W-1:0] r_smp [LANES];
    logic signed [DATA_W-1:0] r_x [LANES];
    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [ACC_W-1:0] r_acc [LANES];

    logic s_acc;
    logic is_last;
    logic out_free;
    logic ram_re;
    logic ram_we;
    logic [AW-1:0] ram_raddr;
    logic [HIST_W-1:0] ram_rdata;
    t_hist rd_hist;
    t_hist wr_hist;
    logic signed [DATA_W-1:0] op_coef;
    logic signed [DATA_W-1:0] op_data [LANES];
    logic signed [DATA_W-1:0] y_sat [LANES];
    logic signed [DATA_W-1:0] g_x [LANES];
    logic [31:0] res_word;

    function automatic logic signed [DATA_W-1:0] round_sat32(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-FRAC_W-1:0] q;
        logic [ACC_W-FRAC_W-DATA_W:0] top;
        begin
            q   = a[ACC_W-1:FRAC_W];
            top = q[ACC_W-FRAC_W-1:DATA_W-1];
            if ((&top) || !(|top)) begin
                round_sat32 = signed'(q[DATA_W-1:0]);
            end else if (q[ACC_W-FRAC_W-1]) begin
                round_sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                round_sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    endfunction

    function automatic logic [SMP_W-1:0] sat16(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-SMP_W:0] top;
        begin
            top = v[DATA_W-1:SMP_W-1];
            if ((&top) || !(|top)) begin
                sat16 = v[SMP_W-1:0];
            end else if (v[DATA_W-1]) begin
                sat16 = {1'b1, {(SMP_W-1){1'b0}}};
            end else begin
                sat16 = {1'b0, {(SMP_W-1){1'b1}}};
            end
        end
    endfunction

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_last    = (r_stage == LAST_STAGE);
    assign out_free   = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign ram_re    = (r_state == S_GAIN) || ((r_state == S_FIN) && !is_last);
    assign ram_raddr = (r_state == S_GAIN) ? '0 : r_stage + AW'(1);
    assign ram_we    = (r_state == S_FIN);
    assign rd_hist   = r_rd_valid ? t_hist'(ram_rdata) : '0;

    cbq_ram #(
        .WIDTH (HIST_W),
        .DEPTH (STAGES),
        .ADDR_W(AW)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_stage),
        .i_wdata(HIST_W'(wr_hist)),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        case (r_tap)
            TAP_FF0: op_coef = r_coef[0];
            TAP_FF1: op_coef = r_coef[1];
            TAP_FF2: op_coef = r_coef[2];
            TAP_FB1: op_coef = r_coef[3];
            TAP_FB2: op_coef = r_coef[4];
            default: op_coef = '0;
        endcase
        for (int l = 0; l < LANES; l++) begin
            case (r_tap)
                TAP_FF0: op_data[l] = r_x[l];
                TAP_FF1: op_data[l] = rd_hist[l].x1;
                TAP_FF2: op_data[l] = rd_hist[l].x2;
                TAP_FB1: op_data[l] = rd_hist[l].y1;
                TAP_FB2: op_data[l] = rd_hist[l].y2;
                default: op_data[l] = '0;
            endcase
        end
    end

    always_comb begin
        logic signed [SMP_W+GAIN_W:0] g_sum;
        for (int l = 0; l < LANES; l++) begin
            g_sum  = r_smp[l] * signed'({1'b0, r_gain});
            g_sum  = g_sum + (SMP_W+GAIN_W+1)'(1 << (GFRAC_W - 1));
            g_x[l] = DATA_W'(signed'(g_sum[SMP_W+GAIN_W:GFRAC_W]));
            y_sat[l] = round_sat32(r_acc[l]);
            wr_hist[l].x1 = r_x[l];
            wr_hist[l].x2 = rd_hist[l].x1;
            wr_hist[l].y1 = y_sat[l];
            wr_hist[l].y2 = rd_hist[l].y1;
        end
    end

    always_comb begin
        if (r_bypass) begin
            res_word = {r_smp[1], r_smp[0]};
        end else begin
            res_word = {sat16(r_x[1]), sat16(r_x[0])};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tap      <= '0;
            r_stage    <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_bypass   <= 1'b0;
            r_m_valid  <= 1'b0;
            r_enable   <= 1'b0;
            r_gain     <= GAIN_W'(4096);
            r_coef[0]  <= DATA_W'(1 << FRAC_W);
            for (int t = 1; t < NTAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else begin
            if (i_m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            if (ram_re) begin
                r_rd_valid <= r_valid[ram_raddr];
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_bypass <= !r_enable;
                        r_state  <= r_enable ? S_GAIN : S_OUT;
                    end
                end
                S_GAIN: begin
                    r_stage <= '0;
                    r_tap   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == TAP_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_valid[r_stage] <= 1'b1;
                    r_tap <= '0;
                    if (is_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_stage <= r_stage + AW'(1);
                        r_state <= S_MAC;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ENABLE: r_enable  <= i_cfg_wdata[0];
                    REG_GAIN:   r_gain    <= i_cfg_wdata[GAIN_W-1:0];
                    REG_FF0:    r_coef[0] <= i_cfg_wdata;
                    REG_FF1:    r_coef[1] <= i_cfg_wdata;
                    REG_FF2:    r_coef[2] <= i_cfg_wdata;
                    REG_FB1:    r_coef[3] <= i_cfg_wdata;
                    REG_FB2:    r_coef[4] <= i_cfg_wdata;
                    default: ;
                endcase
                case (i_cfg_addr)
                    REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2: r_valid <= '0;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_smp[0] <= i_s_tdata[15:0];
            r_smp[1] <= i_s_tdata[31:16];
        end
        if ((r_state == S_OUT) && out_free) begin
            r_m_data <= res_word;
        end
        for (int l = 0; l < LANES; l++) begin
            r_prod[l] <= op_coef * op_data[l];
            if (r_state == S_GAIN) begin
                r_x[l] <= g_x[l];
            end
            if (r_state == S_FIN) begin
                r_x[l] <= y_sat[l];
            end
            if (r_state == S_MAC) begin
                if (r_tap == TAP_FF0) begin
                    r_acc[l] <= ACC_W'(1 << (FRAC_W - 1));
                end else begin
                    r_acc[l] <= r_acc[l] + ACC_W'(r_prod[l]);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_addr == REG_FF0 || i_cfg_addr == REG_FF1 ||
        i_cfg_addr == REG_FF2 || i_cfg_addr == REG_FB1 || i_cfg_addr == REG_FB2))
        |=> (r_valid == '0))
        else $error("history not cleared after coefficient write");
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !r_enable) |=> (r_state == S_OUT && r_bypass))
        else $error("pass-through word did not go straight to output");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN) |=> (r_state == S_MAC && r_stage == '0 && r_tap == '0))
        else $error("filter did not start at first stage");
`endif

endmodule

### tb/cbq_checker.sv
module cbq_checker
    import cbq_pkg::*;
#(
    parameter int STAGES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [31:0]       i_s_tdata,    // [15:0] i_sample, [31:16] q_sample
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [31:0]       i_m_tdata,    // [15:0] i_result, [31:16] q_result
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_addr,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_errors,
    output int                o_checked,
    output int                o_clipped
);

    localparam int HIST_N = LANES * STAGES;
    localparam longint Y_MAX = 64'sh7FFF_FFFF;
    localparam longint Y_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic signed [SMP_W-1:0] q;
        logic signed [SMP_W-1:0] i;
    } t_iq;

    logic                     en;
    logic [GAIN_W-1:0]        gain;
    logic signed [DATA_W-1:0] coef [NTAPS];
    logic signed [DATA_W-1:0] x1 [HIST_N];
    logic signed [DATA_W-1:0] x2 [HIST_N];
    logic signed [DATA_W-1:0] y1 [HIST_N];
    logic signed [DATA_W-1:0] y2 [HIST_N];
    t_iq                      due_iq [$];
    int                       errs = 0;
    int                       checked = 0;
    int                       clipped = 0;

    function automatic void clear_history();
        for (int k = 0; k < HIST_N; k++) begin
            x1[k] = '0;
            x2[k] = '0;
            y1[k] = '0;
            y2[k] = '0;
        end
    endfunction

    function automatic void apply_cfg(logic [CFG_W-1:0] a, logic [DATA_W-1:0] d);
        case (a)
            REG_ENABLE: en = d[0];
            REG_GAIN: gain = d[GAIN_W-1:0];
            REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2: begin
                coef[a - REG_FF0] = d;
                clear_history();
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] biquad_stage(
        logic signed [DATA_W-1:0] x, int k);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] y;
        acc = coef[TAP_FF0] * x + coef[TAP_FF1] * x1[k] + coef[TAP_FF2] * x2[k]
            + coef[TAP_FB1] * y1[k] + coef[TAP_FB2] * y2[k] + (1 <<< (FRAC_W - 1));
        y = acc >>> FRAC_W;
        if (y > Y_MAX) begin
            y = Y_MAX;
        end else if (y < Y_MIN) begin
            y = Y_MIN;
        end
        x2[k] = x1[k];
        x1[k] = x;
        y2[k] = y1[k];
        y1[k] = y[DATA_W-1:0];
        return y[DATA_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] filter_lane(
        logic signed [SMP_W-1:0] s, int lane);
        longint                   g;
        logic signed [DATA_W-1:0] v;
        g = (longint'(s) * longint'(gain) + 2048) >>> GFRAC_W;
        v = g[DATA_W-1:0];
        for (int n = 0; n < STAGES; n++) begin
            v = biquad_stage(v, LANES * n + lane);
        end
        if (v > 32767) begin
            clipped++;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            clipped++;
            return 16'sh8000;
        end
        return v[SMP_W-1:0];
    endfunction

    task automatic report(string msg);
        $display("ERROR t=%0t result %0d: %s", $time, checked, msg);
        errs++;
    endtask

    always @(posedge i_clk) begin
        t_iq got;
        t_iq want;
        t_iq word_in;
        if (!i_rst_n) begin
            en = 1'b0;
            gain = 16'd4096;
            coef[TAP_FF0] = 32'sh2000_0000;
            coef[TAP_FF1] = '0;
            coef[TAP_FF2] = '0;
            coef[TAP_FB1] = '0;
            coef[TAP_FB2] = '0;
            clear_history();
            due_iq.delete();
        end else begin
            if (i_cfg_we) begin
                apply_cfg(i_cfg_addr, i_cfg_wdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (due_iq.size() == 0) begin
                    report($sformatf("unexpected word i=%0d q=%0d", got.i, got.q));
                end else begin
                    want = due_iq.pop_front();
                    if (got.i !== want.i) begin
                        report($sformatf("i_result got %0d expected %0d", got.i, want.i));
                    end
                    if (got.q !== want.q) begin
                        report($sformatf("q_result got %0d expected %0d", got.q, want.q));
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                word_in = i_s_tdata;
                want = word_in;
                if (en) begin
                    want.i = filter_lane(word_in.i, 0);
                    want.q = filter_lane(word_in.q, 1);
                end
                due_iq.push_back(want);
            end
        end
        o_pending <= due_iq.size();
        o_errors  <= errs;
        o_checked <= checked;
        o_clipped <= clipped;
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import cbq_pkg::*;

    localparam int STAGES = 4;
    localparam int BURST = 80;
    localparam logic [CFG_W-1:0]  REG_UNUSED = 3'd7;
    localparam logic [DATA_W-1:0] ONE_Q29 = 32'h2000_0000;
    localparam logic [DATA_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] C_MIN = 32'h8000_0000;
    // low-pass near fs/10, Q about 0.7
    localparam logic [DATA_W-1:0] LP_B0 = 32'sd36238787;
    localparam logic [DATA_W-1:0] LP_B1 = 32'sd72477574;
    localparam logic [DATA_W-1:0] LP_FB1 = 32'sd613643452;
    localparam logic [DATA_W-1:0] LP_FB2 = -32'sd221620312;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_addr = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int pending;
    int errors;
    int checked;
    int clipped;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    complex_biquad_lowpass_cascade #(
        .STAGES(STAGES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    cbq_checker #(
        .STAGES(STAGES)
    ) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata),
        .o_pending  (pending),
        .o_errors   (errors),
        .o_checked  (checked),
        .o_clipped  (clipped)
    );

    initial begin
        #2_000_000;
        $display("complex_biquad_lowpass_cascade test failed");
        $finish;
    end

    task automatic send_word(logic [15:0] i_s, logic [15:0] q_s);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q_s, i_s};
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] a, logic [DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_coefs(logic [DATA_W-1:0] c0, logic [DATA_W-1:0] c1,
                             logic [DATA_W-1:0] c2, logic [DATA_W-1:0] c3,
                             logic [DATA_W-1:0] c4);
        write_reg(REG_FF0, c0);
        write_reg(REG_FF1, c1);
        write_reg(REG_FF2, c2);
        write_reg(REG_FB1, c3);
        write_reg(REG_FB2, c4);
    endtask

    function automatic logic [DATA_W-1:0] near_zero(int span);
        return DATA_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [15:0] rand_sample();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(3))
            2: r = {{6{r[9]}}, r[9:0]};
            3: begin
                case ($urandom_range(3))
                    0: r = 16'h7FFF;
                    1: r = 16'h8000;
                    2: r = 16'h0000;
                    default: r = 16'hFFFF;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // enable and gain always, coefficients (and so a history flush) on request
    task automatic reprogram(bit coefs);
        logic [DATA_W-1:0] d;
        drain();
        if ($urandom_range(7) == 0) begin
            write_reg(REG_UNUSED, $urandom);
        end
        d = $urandom;
        d[0] = ($urandom_range(4) != 0);
        write_reg(REG_ENABLE, d);
        d = $urandom;
        case ($urandom_range(3))
            0: d[15:0] = 16'd4096;
            1: d[15:0] = 16'($urandom_range(8191));
            2: d[15:0] = 16'hFFFF;
            default: ;
        endcase
        write_reg(REG_GAIN, d);
        if (coefs) begin
            case ($urandom_range(3))
                0: set_coefs(LP_B0, LP_B1, LP_B0, LP_FB1, LP_FB2);
                1: set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
                2: set_coefs(near_zero(1 << 29), near_zero(1 << 29), near_zero(1 << 29),
                             near_zero(1 << 28), near_zero(1 << 28));
                default: set_coefs(ONE_Q29, near_zero(1 << 27), near_zero(1 << 27),
                                   '0, '0);
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through after reset
        send_word(16'h0000, 16'h0000);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h5555, 16'hAAAA);
        send_word(16'hFFFF, 16'h0001);

        // reset coefficients form an identity filter
        drain();
        write_reg(REG_ENABLE, 32'd1);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h1234, 16'hEDCB);

        // max gain: clip at 16 bits, rounding of small values
        drain();
        write_reg(REG_GAIN, 32'h0000_FFFF);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h0001, 16'hFFFF);
        send_word(16'h0100, 16'hFF00);

        // extreme coefficients drive the stages into 32-bit saturation
        drain();
        set_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h0000, 16'h0000);
        drain();
        set_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h0000, 16'h0000);

        drain();
        write_reg(REG_GAIN, 32'd4096);
        set_coefs(LP_B0, LP_B1, LP_B0, LP_FB1, LP_FB2);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h7FFF, 16'h8000);

        // history frozen while bypassed, kept across enable writes
        drain();
        write_reg(REG_ENABLE, 32'd0);
        send_word(16'h1111, 16'h2222);
        drain();
        write_reg(REG_ENABLE, 32'hFFFF_FFFF);
        send_word(16'h7FFF, 16'h8000);

        drain();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(16'h0000, 16'h0000);

        // same-value coefficient write still flushes
        drain();
        write_reg(REG_FF0, LP_B0);
        send_word(16'h7FFF, 16'h8000);

        drain();
        write_reg(REG_GAIN, 32'd0);
        send_word(16'h7FFF, 16'h8000);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 68;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 68;
                end
                default: begin
                    idle_pct = 38;
                    stall_pct = 38;
                end
            endcase
            reprogram(1'b1);
            repeat (BURST) send_word(rand_sample(), rand_sample());
            reprogram(1'($urandom_range(1)));
            repeat (BURST) send_word(rand_sample(), rand_sample());
        end

        drain();
        repeat (40) @(posedge i_clk);

        $display("%0d words sent, %0d results checked, %0d lanes clipped to 16 bits",
                 words_sent, checked, clipped);
        $display("bypass, gain and coefficient extremes, flushes, four idle/stall mixes");
        if (errors == 0) begin
            $display("complex_biquad_lowpass_cascade test passed");
        end else begin
            $display("complex_biquad_lowpass_cascade test failed");
        end
        $finish;
    end

endmodule
